// ===== src/msd_pkg.sv =====
// Shared types, field widths and constant tables for the mean squared displacement block.
// Used by msd_lane and mean_squared_displacement; depends on nothing.
package msd_pkg;

  localparam int COORD_W  = 24;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 9;
  localparam int FRAME_W  = 10;
  localparam int PART_W   = 8;
  localparam int LAG_W    = 11;
  localparam int MSD_W    = 48;
  localparam int TOT_W    = 50;
  localparam int PAIR_W   = 19;
  localparam int ACC_W    = 58;
  localparam int SQ_W     = 52;
  localparam int OUT_DIMS = 3;
  localparam int IN_W     = 96;
  localparam int OUT_W    = 224;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam int DIMS_W   = 2;

  localparam logic [CFG_AW-1:0] REG_DIMS_IN_USE = 3'd0;
  localparam logic [DIMS_W-1:0] DIMS_RESET      = 2'd3;
  localparam logic [CNT_W-1:0]  COUNT_MAX       = 9'd511;
  localparam logic [PAIR_W-1:0] PAIR_MAX        = 19'h7FFFF;
  localparam logic [ACC_W-1:0]  MSD_MAX         = 58'h0000FFFFFFFFFFFF;

  localparam int POW_ENTRIES = 50;
  localparam int IDX_W       = 6;

  // round(1.15^i); every later power lies above the largest frame count
  localparam logic [LAG_W-1:0] POW_ROUND [POW_ENTRIES] = '{
    11'd1,   11'd1,   11'd1,   11'd2,   11'd2,   11'd2,   11'd2,   11'd3,   11'd3,   11'd4,
    11'd4,   11'd5,   11'd5,   11'd6,   11'd7,   11'd8,   11'd9,   11'd11,  11'd12,  11'd14,
    11'd16,  11'd19,  11'd22,  11'd25,  11'd29,  11'd33,  11'd38,  11'd44,  11'd50,  11'd58,
    11'd66,  11'd76,  11'd88,  11'd101, 11'd116, 11'd133, 11'd153, 11'd176, 11'd203, 11'd233,
    11'd268, 11'd308, 11'd354, 11'd407, 11'd468, 11'd539, 11'd620, 11'd713, 11'd819, 11'd942
  };

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_LOAD_WR,
    ST_MEAN_RD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_SW_INIT,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIV,
    ST_FIND,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic mean_start;
    logic acc_clear;
    logic hit;
    logic div_start;
  } lane_ctl_t;

endpackage

// ===== src/msd_ram.sv =====
// Generic simple RAM: one write port, two registered read ports.
// Standalone; no package needed.
module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== src/msd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by msd_lane for frame means and final averages.
module msd_div #(
  parameter int NW = 32,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW:0]     rem_r;
  logic [NW-1:0]   quo_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     shifted;
  logic            ge;

  assign shifted  = {rem_r[DW-1:0], quo_r[NW-1]};
  assign ge       = shifted >= {1'b0, divisor};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? (shifted - {1'b0, divisor}) : shifted;
      quo_r <= {quo_r[NW-2:0], ge};
    end
  end

endmodule

// ===== src/msd_lane.sv =====
// One dimension lane: frame mean division, squared displacement accumulation
// and final average division. Depends on msd_pkg and msd_div.
module msd_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msd_pkg::lane_ctl_t            ctl,
  input  logic [msd_pkg::SUM_W-1:0]     sum_in,
  input  logic [msd_pkg::CNT_W-1:0]     cnt_in,
  input  logic signed [msd_pkg::COORD_W-1:0] pos_a,
  input  logic signed [msd_pkg::COORD_W-1:0] pos_b,
  input  logic signed [msd_pkg::COORD_W-1:0] mean_a,
  input  logic signed [msd_pkg::COORD_W-1:0] mean_b,
  input  logic [msd_pkg::PAIR_W-1:0]    pairs,
  output logic                          mean_done,
  output logic [msd_pkg::COORD_W-1:0]   mean_val,
  output logic                          msd_done,
  output logic [msd_pkg::ACC_W-1:0]     msd_q
);
  import msd_pkg::*;

  // frame mean: |sum| / count, sign restored, clamped to 24 bits
  logic [SUM_W-1:0] mag_sum;
  logic [SUM_W-1:0] qm;
  logic             neg_r;
  logic             zero_r;

  assign mag_sum = sum_in[SUM_W-1] ? (~sum_in + 1'b1) : sum_in;

  always_ff @(posedge clk) begin
    if (ctl.mean_start) begin
      neg_r  <= sum_in[SUM_W-1];
      zero_r <= (cnt_in == '0);
    end
  end

  msd_div #(.NW(SUM_W), .DW(CNT_W)) u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.mean_start),
    .dividend (mag_sum),
    .divisor  (cnt_in),
    .done     (mean_done),
    .quotient (qm)
  );

  always_comb begin
    if (zero_r) begin
      mean_val = '0;
    end else if (!neg_r) begin
      mean_val = (qm > 32'd8388607) ? 24'h7FFFFF : qm[COORD_W-1:0];
    end else begin
      mean_val = (qm > 32'd8388608) ? 24'h800000 : (~qm[COORD_W-1:0] + 24'd1);
    end
  end

  // displacement pipeline: difference, square, saturating accumulate
  logic signed [COORD_W:0]   x1;
  logic signed [COORD_W:0]   x2;
  logic signed [COORD_W+1:0] d;
  logic [COORD_W+1:0]        d_mag_r;
  logic [SQ_W-1:0]           sq_r;
  logic                      h1_r;
  logic                      h2_r;
  logic [ACC_W-1:0]          acc_r;
  logic [ACC_W:0]            acc_sum;

  assign x1      = (COORD_W+1)'(pos_a) - (COORD_W+1)'(mean_a);
  assign x2      = (COORD_W+1)'(pos_b) - (COORD_W+1)'(mean_b);
  assign d       = (COORD_W+2)'(x2) - (COORD_W+2)'(x1);
  assign acc_sum = (ACC_W+1)'(acc_r) + (ACC_W+1)'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h1_r <= 1'b0;
      h2_r <= 1'b0;
    end else begin
      h1_r <= ctl.hit;
      h2_r <= h1_r;
    end
  end

  always_ff @(posedge clk) begin
    d_mag_r <= d[COORD_W+1] ? (~d + 1'b1) : d;
    sq_r    <= SQ_W'(d_mag_r) * SQ_W'(d_mag_r);
    if (ctl.acc_clear) begin
      acc_r <= '0;
    end else if (h2_r) begin
      acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
    end
  end

  msd_div #(.NW(ACC_W), .DW(PAIR_W)) u_msd_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_start),
    .dividend (acc_r),
    .divisor  (pairs),
    .done     (msd_done),
    .quotient (msd_q)
  );

endmodule

// ===== src/mean_squared_displacement.sv =====
// Mean squared displacement over log-spaced lags. Load: each item takes a sum
// read, then a write. Run: per frame a drift mean through the 32-bit divider,
// per lag a sweep over parts*(frames-lag) cells through the position RAM read
// ports, then drain, divide and lag search.
// Reset (sync, active low) and the end of each run start a clearing pass over
// all MAX_FRAMES*MAX_PARTICLES cells of the presence RAM, with no item accepted.
module mean_squared_displacement #(
  parameter int MAX_FRAMES     = 1024,
  parameter int MAX_PARTICLES  = 256,
  parameter int MAX_DIMS       = 3,
  parameter int LAG_TABLE_SIZE = 150
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // coord_0, coord_1, coord_2, frame, particle, zero pad
  input  logic [msd_pkg::IN_W-1:0]      in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // lag, msd_0, msd_1, msd_2, msd_total, pair_count
  output logic [msd_pkg::OUT_W-1:0]     out_tdata,
  output logic                          out_tlast,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [msd_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [msd_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [msd_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import msd_pkg::*;

  localparam int FW    = $clog2(MAX_FRAMES);
  localparam int PW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CELLS = MAX_FRAMES * MAX_PARTICLES;
  localparam int CW    = $clog2(CELLS);
  localparam int POSW  = MAX_DIMS * COORD_W;
  localparam int SUMSW = MAX_DIMS * SUM_W + CNT_W;
  localparam int LIM   = (LAG_TABLE_SIZE < POW_ENTRIES) ? LAG_TABLE_SIZE : POW_ENTRIES;

  // configuration
  logic [DIMS_W-1:0] dims_r;
  logic              cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = !cfg_paddr[2] ? CFG_DW'(dims_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
    end else if (cfg_wr) begin
      dims_r <= cfg_pwdata[DIMS_W-1:0];
    end
  end

  // control registers
  state_t            state_r, state_nxt;
  logic [CW-1:0]     clr_r;
  logic [FW-1:0]     hf_r;
  logic [PW-1:0]     hp_r;
  logic [FW-1:0]     t_r;
  logic [PW-1:0]     p_r;
  logic [LAG_W-1:0]  lag_r;
  logic [LAG_W-1:0]  next_lag_r;
  logic [IDX_W-1:0]  idx_r;
  logic [1:0]        drain_r;
  logic [DIMS_W-1:0] dims_eff_r;
  logic [PAIR_W-1:0] pairs_r;
  logic              v1_r;
  logic              last_r;
  logic              out_valid_r;

  // record capture
  logic [POSW-1:0]    rec_pos_r;
  logic [FRAME_W-1:0] rec_frame_r;
  logic [PART_W-1:0]  rec_part_r;
  logic               rec_last_r;
  logic               rec_ok;
  logic [CW-1:0]      rec_cell;

  logic               in_acc;
  logic [LAG_W-1:0]   frames;
  logic               last_t;
  logic               last_p;
  logic [FW-1:0]      t_b;
  logic [CW-1:0]      cell_a;
  logic [CW-1:0]      cell_b;
  logic [LAG_W-1:0]   pw_val;
  logic               pw_end;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign rec_ok    = ({1'b0, rec_frame_r} < LAG_W'(MAX_FRAMES)) &&
                     (13'(rec_part_r) < 13'(MAX_PARTICLES));
  assign rec_cell  = CW'(CW'(rec_frame_r) * CW'(MAX_PARTICLES)) + CW'(rec_part_r);
  assign frames    = LAG_W'(hf_r) + 1'b1;
  assign last_t    = (LAG_W'(t_r) + lag_r + 1'b1) == frames;
  assign last_p    = (p_r == hp_r);
  assign t_b       = FW'(LAG_W'(t_r) + lag_r);
  assign cell_a    = CW'(CW'(t_r) * CW'(MAX_PARTICLES)) + CW'(p_r);
  assign cell_b    = CW'(CW'(t_b) * CW'(MAX_PARTICLES)) + CW'(p_r);
  assign pw_end    = (idx_r >= IDX_W'(LIM));
  assign pw_val    = pw_end ? '0 : POW_ROUND[idx_r];

  // memories
  logic [SUMSW-1:0] sums_rd_a, sums_rd_b, sums_wdata;
  logic             sums_we;
  logic [FW-1:0]    sums_waddr;
  logic [POSW-1:0]  pos_rd_a, pos_rd_b;
  logic             pos_we;
  logic             pres_rd_a, pres_rd_b;
  logic             pres_we;
  logic [CW-1:0]    pres_waddr;
  logic [POSW-1:0]  mean_rd_a, mean_rd_b, mean_wdata;
  logic             mean_we;

  always_comb begin
    sums_wdata = '0;
    if (state_r == ST_CLEAR) begin
      sums_wdata = '0;
    end else begin
      for (int k = 0; k < MAX_DIMS; k++) begin
        sums_wdata[k*SUM_W +: SUM_W] = sums_rd_a[k*SUM_W +: SUM_W] +
          {{(SUM_W-COORD_W){rec_pos_r[k*COORD_W+COORD_W-1]}}, rec_pos_r[k*COORD_W +: COORD_W]};
      end
      sums_wdata[MAX_DIMS*SUM_W +: CNT_W] =
        (sums_rd_a[MAX_DIMS*SUM_W +: CNT_W] == COUNT_MAX) ? COUNT_MAX
          : sums_rd_a[MAX_DIMS*SUM_W +: CNT_W] + 1'b1;
    end
  end

  assign sums_we    = (state_r == ST_CLEAR) ? (32'(clr_r) < 32'(MAX_FRAMES))
                                            : (state_r == ST_LOAD_WR) && rec_ok;
  assign sums_waddr = (state_r == ST_CLEAR) ? clr_r[FW-1:0] : rec_frame_r[FW-1:0];
  assign pos_we     = (state_r == ST_LOAD_WR) && rec_ok;
  assign pres_we    = (state_r == ST_CLEAR) || pos_we;
  assign pres_waddr = (state_r == ST_CLEAR) ? clr_r : rec_cell;

  msd_ram #(.WIDTH(SUMSW), .DEPTH(MAX_FRAMES), .AW(FW)) u_sums_ram (
    .clk (clk), .we (sums_we), .waddr (sums_waddr), .wdata (sums_wdata),
    .raddr_a (in_tdata[3*COORD_W +: FW]), .rdata_a (sums_rd_a),
    .raddr_b (t_r), .rdata_b (sums_rd_b)
  );

  msd_ram #(.WIDTH(POSW), .DEPTH(CELLS), .AW(CW)) u_pos_ram (
    .clk (clk), .we (pos_we), .waddr (rec_cell), .wdata (rec_pos_r),
    .raddr_a (cell_a), .rdata_a (pos_rd_a),
    .raddr_b (cell_b), .rdata_b (pos_rd_b)
  );

  msd_ram #(.WIDTH(1), .DEPTH(CELLS), .AW(CW)) u_pres_ram (
    .clk (clk), .we (pres_we), .waddr (pres_waddr), .wdata (state_r != ST_CLEAR),
    .raddr_a (cell_a), .rdata_a (pres_rd_a),
    .raddr_b (cell_b), .rdata_b (pres_rd_b)
  );

  msd_ram #(.WIDTH(POSW), .DEPTH(MAX_FRAMES), .AW(FW)) u_mean_ram (
    .clk (clk), .we (mean_we), .waddr (t_r), .wdata (mean_wdata),
    .raddr_a (t_r), .rdata_a (mean_rd_a),
    .raddr_b (t_b), .rdata_b (mean_rd_b)
  );

  // lanes
  lane_ctl_t        ctl;
  logic             mean_done [MAX_DIMS];
  logic [COORD_W-1:0] mean_val [MAX_DIMS];
  logic             msd_done [MAX_DIMS];
  logic [ACC_W-1:0] q_arr [OUT_DIMS];

  assign ctl.mean_start = (state_r == ST_MEAN_GO);
  assign ctl.acc_clear  = (state_r == ST_SW_INIT);
  assign ctl.hit        = v1_r && pres_rd_a && pres_rd_b;
  assign ctl.div_start  = (state_r == ST_DRAIN) && (drain_r == 2'd3);
  assign mean_we        = (state_r == ST_MEAN_WAIT) && mean_done[0];

  genvar g;
  generate
    for (g = 0; g < OUT_DIMS; g++) begin : g_lane
      if (g < MAX_DIMS) begin : g_on
        msd_lane u_lane (
          .clk       (clk),
          .rst_n     (rst_n),
          .ctl       (ctl),
          .sum_in    (sums_rd_b[g*SUM_W +: SUM_W]),
          .cnt_in    (sums_rd_b[MAX_DIMS*SUM_W +: CNT_W]),
          .pos_a     (pos_rd_a[g*COORD_W +: COORD_W]),
          .pos_b     (pos_rd_b[g*COORD_W +: COORD_W]),
          .mean_a    (mean_rd_a[g*COORD_W +: COORD_W]),
          .mean_b    (mean_rd_b[g*COORD_W +: COORD_W]),
          .pairs     (pairs_r),
          .mean_done (mean_done[g]),
          .mean_val  (mean_val[g]),
          .msd_done  (msd_done[g]),
          .msd_q     (q_arr[g])
        );
        assign mean_wdata[g*COORD_W +: COORD_W] = mean_val[g];
      end else begin : g_off
        assign q_arr[g] = '0;
      end
    end
  endgenerate

  // merge: mask unused dimensions, saturate, total
  logic [MSD_W-1:0] msd_v [OUT_DIMS];
  logic [TOT_W-1:0] total_v;
  always_comb begin
    total_v = '0;
    for (int k = 0; k < OUT_DIMS; k++) begin
      if ((k < int'(dims_eff_r)) && (pairs_r != '0)) begin
        msd_v[k] = (q_arr[k] > MSD_MAX) ? {MSD_W{1'b1}} : q_arr[k][MSD_W-1:0];
      end else begin
        msd_v[k] = '0;
      end
      total_v = total_v + TOT_W'(msd_v[k]);
    end
  end

  logic [LAG_W-1:0]  o_lag_r;
  logic [MSD_W-1:0]  o_msd_r [OUT_DIMS];
  logic [TOT_W-1:0]  o_tot_r;
  logic [PAIR_W-1:0] o_pair_r;
  logic              o_last_r;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {o_pair_r, o_tot_r, o_msd_r[2], o_msd_r[1], o_msd_r[0], o_lag_r};

  logic [DIMS_W-1:0] dims_clamp;
  assign dims_clamp = (dims_r == '0) ? DIMS_W'(1)
                    : ((32'(dims_r) > 32'(MAX_DIMS)) ? DIMS_W'(MAX_DIMS) : dims_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (clr_r == CW'(CELLS - 1)) state_nxt = ST_LOAD;
      ST_LOAD:      if (in_acc) state_nxt = ST_LOAD_WR;
      ST_LOAD_WR:   state_nxt = rec_last_r ? ST_MEAN_RD : ST_LOAD;
      ST_MEAN_RD:   state_nxt = ST_MEAN_GO;
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: begin
        if (mean_done[0]) state_nxt = (t_r == hf_r) ? ST_SW_INIT : ST_MEAN_RD;
      end
      ST_SW_INIT:   state_nxt = (lag_r >= frames) ? ST_DRAIN : ST_SWEEP;
      ST_SWEEP:     if (last_t && last_p) state_nxt = ST_DRAIN;
      ST_DRAIN:     if (drain_r == 2'd3) state_nxt = ST_DIV;
      ST_DIV:       if (msd_done[0]) state_nxt = ST_FIND;
      ST_FIND: begin
        if (pw_end || pw_val > frames || pw_val != lag_r) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready) state_nxt = last_r ? ST_CLEAR : ST_SW_INIT;
      end
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hf_r        <= '0;
      hp_r        <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_SWEEP);
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          hf_r  <= '0;
          hp_r  <= '0;
        end
        ST_LOAD_WR: begin
          if (rec_ok) begin
            if (FW'(rec_frame_r) > hf_r) hf_r <= FW'(rec_frame_r);
            if (PW'(rec_part_r) > hp_r) hp_r <= PW'(rec_part_r);
          end
        end
        ST_FIND: begin
          if (state_nxt == ST_EMIT) out_valid_r <= 1'b1;
        end
        ST_EMIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            clr_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath and loop counters
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rec_pos_r   <= in_tdata[POSW-1:0];
      rec_frame_r <= in_tdata[3*COORD_W +: FRAME_W];
      rec_part_r  <= in_tdata[3*COORD_W+FRAME_W +: PART_W];
      rec_last_r  <= in_tlast;
    end
    case (state_r)
      ST_LOAD_WR: begin
        t_r        <= '0;
        lag_r      <= LAG_W'(1);
        idx_r      <= '0;
        dims_eff_r <= dims_clamp;
      end
      ST_MEAN_WAIT: begin
        if (mean_done[0]) t_r <= (t_r == hf_r) ? '0 : t_r + 1'b1;
      end
      ST_SW_INIT: begin
        t_r     <= '0;
        p_r     <= '0;
        pairs_r <= '0;
        drain_r <= '0;
      end
      ST_SWEEP: begin
        if (last_t) begin
          t_r <= '0;
          p_r <= p_r + 1'b1;
        end else begin
          t_r <= t_r + 1'b1;
        end
      end
      ST_DRAIN: drain_r <= drain_r + 1'b1;
      ST_FIND: begin
        if (pw_end || pw_val > frames) begin
          last_r <= 1'b1;
        end else if (pw_val == lag_r) begin
          idx_r <= idx_r + 1'b1;
        end else begin
          last_r     <= 1'b0;
          next_lag_r <= pw_val;
        end
        o_lag_r    <= lag_r;
        o_msd_r[0] <= msd_v[0];
        o_msd_r[1] <= msd_v[1];
        o_msd_r[2] <= msd_v[2];
        o_tot_r    <= total_v;
        o_pair_r   <= pairs_r;
        o_last_r   <= pw_end || pw_val > frames;
      end
      ST_EMIT: begin
        if (out_tready && !last_r) lag_r <= next_lag_r;
      end
      default: ;
    endcase
    if (ctl.hit && pairs_r != PAIR_MAX) pairs_r <= pairs_r + 1'b1;
  end

endmodule
